// ----- hw/rtl/bakery_ticket_lock_arbiter_defines.svh -----
// Assertion macros used by the checker file of the ticket lock arbiter.
`ifndef BAKERY_TICKET_LOCK_ARBITER_DEFINES_SVH
`define BAKERY_TICKET_LOCK_ARBITER_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define BTLA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: label");

// Next-cycle implication, held off during reset.
`define BTLA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: label");

`endif

// ----- hw/rtl/btla_pkg.sv -----
// ----------------------------------------------------------------------------
// btla_pkg
// Request codes and the command/status bundles between controller and
// datapath of the bakery ticket lock arbiter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package btla_pkg;

    localparam logic [1:0] REQ_TAKE    = 2'd0;
    localparam logic [1:0] REQ_POLL    = 2'd1;
    localparam logic [1:0] REQ_RELEASE = 2'd2;

    localparam int REQ_W    = 2;
    localparam int ID_W     = 3;
    localparam int TICKET_W = 16;
    localparam int CFG_W    = 4;
    localparam logic [CFG_W-1:0] ACTIVE_RESET = 4'd8;

    // controller -> datapath
    typedef struct packed {
        logic accept;   // input beat taken this cycle
        logic rd_self;  // read the requester's own ticket
        logic rd_scan;  // read the next ticket of the scan
        logic finish;   // commit state and load the result register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic bad_id;     // client id outside the client range
        logic scan_zero;  // scan covers no client
        logic scan_last;  // current scan read is the last one
        logic out_free;   // result register can take a new beat
    } t_sts;

endpackage

`default_nettype wire

// ----- hw/rtl/btla_ctrl.sv -----
// ----------------------------------------------------------------------------
// btla_ctrl
// Sequencer for one request: own-ticket read, ticket scan, drain, commit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module btla_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire btla_pkg::t_sts i_sts,
    output btla_pkg::t_cmd     o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_READ  = 5'b00010,
        S_SCAN  = 5'b00100,
        S_DRAIN = 5'b01000,
        S_FIN   = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_in_stall     = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall   = 1'b0;
                o_cmd.accept = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd_self = !i_sts.bad_id;
                if (i_sts.bad_id) begin
                    n_state = S_FIN;
                end else if (i_sts.scan_zero) begin
                    n_state = S_DRAIN;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.rd_scan = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                // hold until the result register is free
                o_cmd.finish = i_sts.out_free;
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hw/rtl/btla_dp.sv -----
// ----------------------------------------------------------------------------
// btla_dp
// Ticket memory, waiting flags, scan accumulators and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module btla_dp #(
    parameter int NUM_CLIENTS = 8,
    parameter int TICKET_BITS = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [btla_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  wire logic [btla_pkg::REQ_W-1:0]     i_req_type,
    input  wire logic [btla_pkg::ID_W-1:0]      i_client_id,
    input  wire btla_pkg::t_cmd                 i_cmd,
    output btla_pkg::t_sts                      o_sts,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic                                o_granted,
    output logic [btla_pkg::TICKET_W-1:0]       o_ticket,
    output logic                                o_overflow
);

    localparam int CW  = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;
    localparam int SNW = CW + 1;
    localparam int CPW = (TICKET_BITS < btla_pkg::TICKET_W) ? TICKET_BITS
                                                            : btla_pkg::TICKET_W;
    localparam logic [TICKET_BITS-1:0] TICKET_TOP = '1;

    // configuration and request
    logic [btla_pkg::CFG_W-1:0]   r_active;
    logic [btla_pkg::REQ_W-1:0]   r_req;
    logic [CW-1:0]                r_id;
    logic                         r_bad;

    // storage
    logic [TICKET_BITS-1:0]       mem [NUM_CLIENTS];
    logic [NUM_CLIENTS-1:0]       r_tvalid;
    logic [NUM_CLIENTS-1:0]       r_wait;
    logic [TICKET_BITS-1:0]       r_rdata;
    logic                         r_rvalid;

    // scan
    logic [SNW-1:0]               r_idx;
    logic                         r_p_self;
    logic                         r_p_scan;
    logic [CW-1:0]                r_p_idx;
    logic [TICKET_BITS-1:0]       r_mine;
    logic [TICKET_BITS-1:0]       r_top;
    logic                         r_other_wait;
    logic                         r_block_sat;
    logic                         r_block;

    logic [SNW-1:0]               scan_n;
    logic [CW-1:0]                rd_addr;
    logic                         rd_en;
    logic [TICKET_BITS-1:0]       rd_tk;
    logic                         other;
    logic                         sat;
    logic [TICKET_BITS-1:0]       new_tk;
    logic                         take_wr;

    always_comb begin
        if (32'(r_active) > NUM_CLIENTS) begin
            scan_n = SNW'(NUM_CLIENTS);
        end else begin
            scan_n = SNW'(r_active);
        end
    end

    assign rd_en    = i_cmd.rd_self | i_cmd.rd_scan;
    assign rd_addr  = i_cmd.rd_self ? r_id : r_idx[CW-1:0];
    // an entry never written reads as zero
    assign rd_tk    = r_rvalid ? r_rdata : '0;
    assign other    = (r_p_idx != r_id) && r_wait[r_p_idx];
    assign sat      = (r_top == TICKET_TOP);
    assign new_tk   = sat ? TICKET_TOP : r_top + 1'b1;
    assign take_wr  = i_cmd.finish && !r_bad && (r_req == btla_pkg::REQ_TAKE);

    assign o_sts.bad_id    = r_bad;
    assign o_sts.scan_zero = (scan_n == '0);
    assign o_sts.scan_last = (SNW'(r_idx + 1'b1) == scan_n);
    assign o_sts.out_free  = !o_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= btla_pkg::ACTIVE_RESET;
        end else if (i_cfg_we) begin
            r_active <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req <= i_req_type;
            r_id  <= CW'(i_client_id);
            r_bad <= (32'(i_client_id) >= NUM_CLIENTS);
        end
    end

    // ticket memory
    always_ff @(posedge i_clk) begin
        if (take_wr) begin
            mem[r_id] <= new_tk;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tvalid <= '0;
            r_wait   <= '0;
            r_rvalid <= 1'b0;
        end else begin
            if (rd_en) begin
                r_rvalid <= r_tvalid[rd_addr];
            end
            if (take_wr) begin
                r_tvalid[r_id] <= 1'b1;
                r_wait[r_id]   <= 1'b1;
            end
            if (i_cmd.finish && !r_bad && (r_req == btla_pkg::REQ_RELEASE)) begin
                r_wait[r_id] <= 1'b0;
            end
        end
    end

    // read tags follow the memory latency
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_p_self <= 1'b0;
            r_p_scan <= 1'b0;
        end else begin
            r_p_self <= i_cmd.rd_self;
            r_p_scan <= i_cmd.rd_scan;
            if (i_cmd.accept) begin
                r_idx <= '0;
            end else if (i_cmd.rd_scan) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_idx <= r_idx[CW-1:0];
        if (i_cmd.accept) begin
            r_mine       <= '0;
            r_top        <= '0;
            r_other_wait <= 1'b0;
            r_block_sat  <= 1'b0;
            r_block      <= 1'b0;
        end else begin
            if (r_p_self) begin
                r_mine <= rd_tk;
            end
            if (r_p_scan) begin
                if (rd_tk > r_top) begin
                    r_top <= rd_tk;
                end
                // a fresh ticket sits above every scanned one, so any other waiter
                // blocks it; once saturated, only lower tickets or lower ids do
                if (other) begin
                    r_other_wait <= 1'b1;
                end
                if (other && (rd_tk != TICKET_TOP || r_p_idx < r_id)) begin
                    r_block_sat <= 1'b1;
                end
                if (other && (rd_tk < r_mine || (rd_tk == r_mine && r_p_idx < r_id))) begin
                    r_block <= 1'b1;
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            if (r_bad) begin
                o_granted  <= 1'b0;
                o_overflow <= 1'b0;
                o_ticket   <= '0;
            end else begin
                case (r_req)
                    btla_pkg::REQ_TAKE: begin
                        o_granted  <= sat ? !r_block_sat : !r_other_wait;
                        o_overflow <= sat;
                        o_ticket   <= btla_pkg::TICKET_W'(new_tk[CPW-1:0]);
                    end
                    btla_pkg::REQ_POLL: begin
                        o_granted  <= !r_block;
                        o_overflow <= 1'b0;
                        o_ticket   <= btla_pkg::TICKET_W'(r_mine[CPW-1:0]);
                    end
                    default: begin
                        o_granted  <= 1'b0;
                        o_overflow <= 1'b0;
                        o_ticket   <= btla_pkg::TICKET_W'(r_mine[CPW-1:0]);
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/bakery_ticket_lock_arbiter.sv -----
// ----------------------------------------------------------------------------
// bakery_ticket_lock_arbiter
// Ticket-order lock arbiter for up to NUM_CLIENTS clients.
// ----------------------------------------------------------------------------
// One request is worked at a time. A request that names a client in range is
// accepted, reads the requester's own ticket, scans the stored tickets of the
// first n clients, where n is active_clients capped at NUM_CLIENTS, then drains
// the memory read latency and commits. A client id outside the range skips the
// reads and the scan. The commit waits while the result register is held by a
// stall. The result sits in an output register; the next request is taken once
// the previous one has been committed to it.
`timescale 1ns / 1ps
`default_nettype none

module bakery_ticket_lock_arbiter #(
    parameter int NUM_CLIENTS = 8,
    parameter int TICKET_BITS = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [btla_pkg::CFG_W-1:0] i_cfg_wdata,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire logic [btla_pkg::REQ_W-1:0] i_req_type,
    input  wire logic [btla_pkg::ID_W-1:0]  i_client_id,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output logic                            o_granted,
    output logic [btla_pkg::TICKET_W-1:0]   o_ticket,
    output logic                            o_overflow
);

    btla_pkg::t_cmd cmd;
    btla_pkg::t_sts sts;

    btla_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    btla_dp #(
        .NUM_CLIENTS (NUM_CLIENTS),
        .TICKET_BITS (TICKET_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req_type  (i_req_type),
        .i_client_id (i_client_id),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_granted   (o_granted),
        .o_ticket    (o_ticket),
        .o_overflow  (o_overflow)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/btla_checker.sv -----
// ----------------------------------------------------------------------------
// btla_checker
// Port-level checks of the ticket lock arbiter, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "bakery_ticket_lock_arbiter_defines.svh"

module btla_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_in_valid,
    input wire logic                       o_in_stall,
    input wire logic                       o_out_valid,
    input wire logic                       i_out_stall,
    input wire logic                       o_granted,
    input wire logic [btla_pkg::TICKET_W-1:0] o_ticket,
    input wire logic                       o_overflow
);

    logic in_beat;

    assign in_beat = i_in_valid && !o_in_stall;

    // a held result stays up
    `BTLA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)

    // a held result keeps its payload
    `BTLA_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && i_out_stall,
                      $stable({o_granted, o_ticket, o_overflow}))

    // one request at a time: stall rises right after an input beat
    `BTLA_ASSERT_NEXT(a_busy_after_beat, i_clk, i_rst_n, in_beat, o_in_stall)

    // a request is never answered in the cycle after it is taken
    `BTLA_ASSERT_NEXT(a_no_early_result, i_clk, i_rst_n, in_beat && !o_out_valid, !o_out_valid)

    // a saturated ticket is the top value, never zero
    `BTLA_ASSERT_NOW(a_ovf_ticket, i_clk, i_rst_n, o_out_valid && o_overflow, o_ticket != '0)

endmodule

bind bakery_ticket_lock_arbiter btla_checker u_btla_checker (.*);

`default_nettype wire
